>>> rtl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HSV to RGB converter package
// Transaction types, fixed-point constants and hue sector codes shared by
// the converter RTL.
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

    // One HSV colour, all fields two's complement.
    typedef struct packed {
        logic signed [15:0] hue_in;
        logic signed [15:0] sat_in;
        logic signed [15:0] val_in;
    } t_hsv;

    // One RGB triple.
    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_rgb;

    // Clamp limits: hue in 1/16 degree, saturation and value in 1/16 percent.
    localparam logic [12:0] HUE_MAX  = 13'd5760;
    localparam logic [10:0] PCT_MAX  = 11'd1600;

    // Width of one 60 degree sector in hue units, and its multiples.
    localparam logic [9:0]  SECTOR_W = 10'd960;
    localparam logic [12:0] HUE_SEC1 = 13'd960;
    localparam logic [12:0] HUE_SEC2 = 13'd1920;
    localparam logic [12:0] HUE_SEC3 = 13'd2880;
    localparam logic [12:0] HUE_SEC4 = 13'd3840;
    localparam logic [12:0] HUE_SEC5 = 13'd4800;

    // Unity for the term (1 - s*x), scaled by 1600 * 960.
    localparam logic [20:0] FULL_ONE = 21'd1536000;

    // Rounding offset D = 1600 * 1600 * 960; the divisor 2D is 2^19 * 9375.
    localparam logic [40:0] ROUND_BIAS = 41'd2457600000;
    localparam int          QUOT_LSB   = 19;

    // Reciprocal of 9375: ceil(2^36 / 9375), exact for dividends below 2^22.
    localparam logic [22:0] RECIP       = 23'd7330078;
    localparam int          RECIP_SHIFT = 36;

    // Hue sector codes.
    localparam logic [2:0] SECTOR_RY = 3'd0;
    localparam logic [2:0] SECTOR_YG = 3'd1;
    localparam logic [2:0] SECTOR_GC = 3'd2;
    localparam logic [2:0] SECTOR_CB = 3'd3;
    localparam logic [2:0] SECTOR_BM = 3'd4;
    localparam logic [2:0] SECTOR_MR = 3'd5;

    // Lane numbers of the three colour channels.
    localparam int LANE_R = 0;
    localparam int LANE_G = 1;
    localparam int LANE_B = 2;

endpackage

>>> rtl/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HSV to RGB converter
// Five-stage pipeline that turns one HSV colour per clock into an 8-bit
// RGB triple using exact fixed-point arithmetic with round half up.
// ---------------------------------------------------------------------------
// The converter accepts a new transaction in every clock cycle: busy is
// always low, so a colour is taken at every rising edge at which start is
// high. Each result is shown on o_rgb, marked by o_valid, for one cycle,
// once its colour has passed the five register stages. Results leave in
// the order that colours arrived. The receiver cannot stall the block and
// must take each result in the cycle that it is shown. The five register
// stages are: clamp and sector split, the saturation products, the value
// products, the scaling add, and the reciprocal multiply that divides
// by the fixed denominator. Hue is in 1/16 degree and is clamped to 0..5760,
// saturation and value are in 1/16 percent and are clamped to 0..1600. A hue
// of exactly 360 degrees gives the same colour as 0 degrees.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  hsv2rgb_pkg::t_hsv i_hsv,
    output logic              o_valid,
    output hsv2rgb_pkg::t_rgb o_rgb
);
    import hsv2rgb_pkg::*;

    // -----------------------------------------------------------------------
    // Stage 1: clamp the inputs and split the hue into sector and fraction.
    // -----------------------------------------------------------------------
    logic [12:0] n_hue;
    logic [10:0] n_sat1;
    logic [10:0] n_val1;
    logic [2:0]  n_sec1;
    logic [12:0] n_base1;
    logic [12:0] n_frac_full;

    logic        r_vld1;
    logic [2:0]  r_sec1;
    logic [9:0]  r_frac1;
    logic [10:0] r_sat1;
    logic [10:0] r_val1;

    always_comb begin
        if (i_hsv.hue_in < 16'sd0) begin
            n_hue = '0;
        end else if (i_hsv.hue_in > $signed({3'b000, HUE_MAX})) begin
            n_hue = HUE_MAX;
        end else begin
            n_hue = i_hsv.hue_in[12:0];
        end

        if (i_hsv.sat_in < 16'sd0) begin
            n_sat1 = '0;
        end else if (i_hsv.sat_in > $signed({5'b00000, PCT_MAX})) begin
            n_sat1 = PCT_MAX;
        end else begin
            n_sat1 = i_hsv.sat_in[10:0];
        end

        if (i_hsv.val_in < 16'sd0) begin
            n_val1 = '0;
        end else if (i_hsv.val_in > $signed({5'b00000, PCT_MAX})) begin
            n_val1 = PCT_MAX;
        end else begin
            n_val1 = i_hsv.val_in[10:0];
        end

        // The full circle falls into the last sector with a whole fraction.
        if (n_hue >= HUE_SEC5) begin
            n_sec1  = SECTOR_MR;
            n_base1 = HUE_SEC5;
        end else if (n_hue >= HUE_SEC4) begin
            n_sec1  = SECTOR_BM;
            n_base1 = HUE_SEC4;
        end else if (n_hue >= HUE_SEC3) begin
            n_sec1  = SECTOR_CB;
            n_base1 = HUE_SEC3;
        end else if (n_hue >= HUE_SEC2) begin
            n_sec1  = SECTOR_GC;
            n_base1 = HUE_SEC2;
        end else if (n_hue >= HUE_SEC1) begin
            n_sec1  = SECTOR_YG;
            n_base1 = HUE_SEC1;
        end else begin
            n_sec1  = SECTOR_RY;
            n_base1 = '0;
        end
        n_frac_full = n_hue - n_base1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= start;
        end
        r_sec1  <= n_sec1;
        r_frac1 <= n_frac_full[9:0];
        r_sat1  <= n_sat1;
        r_val1  <= n_val1;
    end

    // -----------------------------------------------------------------------
    // Stage 2: form the scaled terms 1 - s*x for p, q and t, then route them
    // to the channels by sector. The v term is the constant unity.
    // -----------------------------------------------------------------------
    logic [20:0] n_sx_p;
    logic [20:0] n_sx_q;
    logic [20:0] n_sx_t;
    logic [20:0] n_w_p;
    logic [20:0] n_w_q;
    logic [20:0] n_w_t;
    logic [20:0] n_w2 [3];

    logic        r_vld2;
    logic [10:0] r_val2;
    logic [20:0] r_w2 [3];

    always_comb begin
        n_sx_p = 21'(r_sat1) * 21'(SECTOR_W);
        n_sx_q = 21'(r_sat1) * 21'(r_frac1);
        n_sx_t = 21'(r_sat1) * 21'(SECTOR_W - r_frac1);
        n_w_p  = FULL_ONE - n_sx_p;
        n_w_q  = FULL_ONE - n_sx_q;
        n_w_t  = FULL_ONE - n_sx_t;

        case (r_sec1)
            SECTOR_RY: begin
                n_w2[LANE_R] = FULL_ONE;
                n_w2[LANE_G] = n_w_t;
                n_w2[LANE_B] = n_w_p;
            end
            SECTOR_YG: begin
                n_w2[LANE_R] = n_w_q;
                n_w2[LANE_G] = FULL_ONE;
                n_w2[LANE_B] = n_w_p;
            end
            SECTOR_GC: begin
                n_w2[LANE_R] = n_w_p;
                n_w2[LANE_G] = FULL_ONE;
                n_w2[LANE_B] = n_w_t;
            end
            SECTOR_CB: begin
                n_w2[LANE_R] = n_w_p;
                n_w2[LANE_G] = n_w_q;
                n_w2[LANE_B] = FULL_ONE;
            end
            SECTOR_BM: begin
                n_w2[LANE_R] = n_w_t;
                n_w2[LANE_G] = n_w_p;
                n_w2[LANE_B] = FULL_ONE;
            end
            default: begin
                n_w2[LANE_R] = FULL_ONE;
                n_w2[LANE_G] = n_w_p;
                n_w2[LANE_B] = n_w_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
        r_val2 <= r_val1;
        r_w2   <= n_w2;
    end

    // -----------------------------------------------------------------------
    // Stage 3: multiply each channel term by the value.
    // -----------------------------------------------------------------------
    logic [31:0] n_prod3 [3];
    logic        r_vld3;
    logic [31:0] r_prod3 [3];

    always_comb begin
        for (int lane = 0; lane < 3; lane++) begin
            n_prod3[lane] = 32'(r_val2) * 32'(r_w2[lane]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else begin
            r_vld3 <= r_vld2;
        end
        r_prod3 <= n_prod3;
    end

    // -----------------------------------------------------------------------
    // Stage 4: numerator 510*P + D for round half up. The divisor 2D has a
    // factor 2^19, which is dropped here by taking the upper bits.
    // -----------------------------------------------------------------------
    logic [40:0] n_num4 [3];
    logic [21:0] n_quo4 [3];
    logic        r_vld4;
    logic [21:0] r_quo4 [3];

    always_comb begin
        for (int lane = 0; lane < 3; lane++) begin
            n_num4[lane] = {r_prod3[lane], 9'b0} - {8'b0, r_prod3[lane], 1'b0} + ROUND_BIAS;
            n_quo4[lane] = n_num4[lane][QUOT_LSB +: 22];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else begin
            r_vld4 <= r_vld3;
        end
        r_quo4 <= n_quo4;
    end

    // -----------------------------------------------------------------------
    // Stage 5: divide by the odd factor 9375 through its reciprocal. The
    // quotient never exceeds 255, so the low eight bits above the shift are
    // the whole result.
    // -----------------------------------------------------------------------
    logic [44:0] n_recip5 [3];
    logic [7:0]  n_chan5  [3];
    logic        r_vld5;
    t_rgb        r_rgb;

    always_comb begin
        for (int lane = 0; lane < 3; lane++) begin
            n_recip5[lane] = 45'(r_quo4[lane]) * 45'(RECIP);
            n_chan5[lane]  = n_recip5[lane][RECIP_SHIFT +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
        end else begin
            r_vld5 <= r_vld4;
        end
        r_rgb.red_out   <= n_chan5[LANE_R];
        r_rgb.green_out <= n_chan5[LANE_G];
        r_rgb.blue_out  <= n_chan5[LANE_B];
    end

    // The pipeline never stalls, so a new transaction is always welcome.
    assign busy    = 1'b0;
    assign o_valid = r_vld5;
    assign o_rgb   = r_rgb;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    a_latency_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##5 o_valid)
        else $error("result missing five cycles after a transaction");

    a_latency_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##5 !o_valid)
        else $error("result without a matching transaction");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_hsv.sat_in <= 16'sd0) |-> ##5
            (o_rgb.red_out == o_rgb.green_out && o_rgb.green_out == o_rgb.blue_out))
        else $error("zero saturation did not give grey");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_hsv.val_in <= 16'sd0) |-> ##5
            (o_rgb.red_out == 8'd0 && o_rgb.green_out == 8'd0 && o_rgb.blue_out == 8'd0))
        else $error("zero value did not give black");

endmodule
